// ===== rtl/lspf_pkg.sv =====
// Package for the LiDAR scan point filter: widths, constants, register codes,
// the arctangent table and the transaction type passed between pipeline cells.
// No dependencies.
package lspf_pkg;

  localparam int RANGE_W  = 16;
  localparam int COORD_W  = 17;
  localparam int ANGLE_W  = 18;
  localparam int START_W  = 16;
  localparam int STEP_W   = 11;
  localparam int STRIDE_W = 8;
  localparam int MAXR_W   = 17;
  localparam int CFG_W    = 17;
  localparam int CFG_AW   = 2;

  localparam int XW = 36;
  localparam int ZW = 34;
  localparam int RW = 40;
  localparam int PW = 33;
  localparam int GAIN_PROD_W = 46;

  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 13;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = PI_Q30 / 2;
  localparam longint TWO_PI_Q30  = 2 * PI_Q30;
  localparam longint GAIN_Q30    = 64'sd652032874;

  localparam logic [MAXR_W-1:0]          MAX_RANGE_RST     = 17'h10000;
  localparam logic signed [START_W-1:0]  ANGLE_START_RST   = -16'sd25736;
  localparam logic [STEP_W-1:0]          ANGLE_STEP_RST    = 11'd36;
  localparam logic [STRIDE_W-1:0]        SAMPLE_STRIDE_RST = 8'd1;

  typedef enum logic [CFG_AW-1:0] {
    REG_MAX_RANGE,
    REG_ANGLE_START,
    REG_ANGLE_STEP,
    REG_SAMPLE_STRIDE
  } lspf_reg_t;

  typedef struct packed {
    logic                 last;
    logic                 kept;
    logic                 zneg;
    logic                 neg;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [RW-1:0]        z;
  } lspf_item_t;

  function automatic logic [29:0] atan_q30(input int unsigned idx);
    logic [29:0] v;
    case (idx)
      0:  v = 30'd843314856;
      1:  v = 30'd497837829;
      2:  v = 30'd263043836;
      3:  v = 30'd133525158;
      4:  v = 30'd67021686;
      5:  v = 30'd33543515;
      6:  v = 30'd16775850;
      7:  v = 30'd8388437;
      8:  v = 30'd4194282;
      9:  v = 30'd2097149;
      10: v = 30'd1048575;
      11: v = 30'd524287;
      12: v = 30'd262143;
      13: v = 30'd131071;
      14: v = 30'd65535;
      15: v = 30'd32767;
      16: v = 30'd16383;
      17: v = 30'd8191;
      18: v = 30'd4095;
      19: v = 30'd2047;
      20: v = 30'd1023;
      21: v = 30'd511;
      22: v = 30'd255;
      23: v = 30'd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/lspf_front.sv =====
// Front end of the scan point filter: configuration registers, beam angle and
// stride tracking, range gate, pillar bands, gain multiply. Uses lspf_pkg.
module lspf_front #(
  parameter int ANGLE_FRAC_BITS = lspf_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lspf_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [lspf_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lspf_pkg::RANGE_W-1:0]  range_mm,
  input  logic                          range_finite,
  input  logic                          scan_last,
  output logic                          dn_valid,
  output lspf_pkg::lspf_item_t          dn_item,
  input  logic                          dn_ready
);
  import lspf_pkg::*;

  localparam longint UNIT = longint'(1) << ANGLE_FRAC_BITS;
  localparam logic signed [PW-1:0] SCALE = 33'sd10000;
  localparam logic signed [PW-1:0] B0_LO = PW'(-25436 * UNIT);
  localparam logic signed [PW-1:0] B0_HI = PW'(-21564 * UNIT);
  localparam logic signed [PW-1:0] B1_LO = PW'(21564 * UNIT);
  localparam logic signed [PW-1:0] B1_HI = PW'(25436 * UNIT);
  localparam logic signed [PW-1:0] B2_LO = PW'(6064 * UNIT);
  localparam logic signed [PW-1:0] B2_HI = PW'(9936 * UNIT);
  localparam logic signed [PW-1:0] B3_LO = PW'(-9936 * UNIT);
  localparam logic signed [PW-1:0] B3_HI = PW'(-6064 * UNIT);

  logic [MAXR_W-1:0]          max_range;
  logic signed [START_W-1:0]  angle_start;
  logic [STEP_W-1:0]          angle_step;
  logic [STRIDE_W-1:0]        sample_stride;
  logic signed [ANGLE_W-1:0]  beam_angle;
  logic [STRIDE_W-1:0]        stride_count;

  logic                 accept;
  logic [STRIDE_W-1:0]  stride_eff;
  logic [STRIDE_W:0]    count_inc;
  logic                 cand;

  logic                      a_valid;
  logic [RANGE_W-1:0]        a_range;
  logic signed [ANGLE_W-1:0] a_angle;
  logic                      a_last;
  logic                      a_cand;
  logic [ANGLE_W-1:0]        a_abs;
  logic                      ready_a;

  logic                      b_valid;
  logic signed [PW-1:0]      b_lhs;
  logic signed [XW-1:0]      b_x0;
  logic [RW-1:0]             b_mag;
  logic                      b_zneg;
  logic                      b_last;
  logic                      b_cand;
  logic                      ready_b;
  logic [GAIN_PROD_W-1:0]    gain_prod;

  logic pillar;
  logic kept;
  logic ready_c;

  assign ready_c  = !dn_valid || dn_ready;
  assign ready_b  = !b_valid || ready_c;
  assign ready_a  = !a_valid || ready_b;
  assign in_stall = !ready_a;
  assign accept   = in_valid && ready_a;

  assign stride_eff = (sample_stride == '0) ? STRIDE_W'(1) : sample_stride;
  assign count_inc  = {1'b0, stride_count} + (STRIDE_W + 1)'(1);
  assign cand       = (stride_count == '0) && range_finite &&
                      ({1'b0, range_mm} < max_range);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_range     <= MAX_RANGE_RST;
      angle_start   <= ANGLE_START_RST;
      angle_step    <= ANGLE_STEP_RST;
      sample_stride <= SAMPLE_STRIDE_RST;
      beam_angle    <= ANGLE_W'(ANGLE_START_RST);
      stride_count  <= '0;
    end else if (cfg_we) begin
      case (lspf_reg_t'(cfg_addr))
        REG_MAX_RANGE: begin
          max_range <= cfg_wdata[MAXR_W-1:0];
        end
        REG_ANGLE_START: begin
          angle_start  <= signed'(cfg_wdata[START_W-1:0]);
          beam_angle   <= ANGLE_W'(signed'(cfg_wdata[START_W-1:0]));
          stride_count <= '0;
        end
        REG_ANGLE_STEP: begin
          angle_step <= cfg_wdata[STEP_W-1:0];
        end
        REG_SAMPLE_STRIDE: begin
          sample_stride <= cfg_wdata[STRIDE_W-1:0];
        end
        default: begin
          max_range <= max_range;
        end
      endcase
    end else if (accept) begin
      if (scan_last) begin
        beam_angle   <= ANGLE_W'(angle_start);
        stride_count <= '0;
      end else begin
        beam_angle <= beam_angle + signed'(ANGLE_W'(angle_step));
        if (count_inc >= {1'b0, stride_eff}) begin
          stride_count <= '0;
        end else begin
          stride_count <= count_inc[STRIDE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (ready_a) begin
      a_valid <= in_valid && (cand || scan_last);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_range <= range_mm;
      a_angle <= beam_angle;
      a_last  <= scan_last;
      a_cand  <= cand;
    end
  end

  assign a_abs     = a_angle[ANGLE_W-1] ? ANGLE_W'(-a_angle) : ANGLE_W'(a_angle);
  assign gain_prod = GAIN_PROD_W'(a_range) * GAIN_PROD_W'(GAIN_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (ready_b) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b && a_valid) begin
      b_lhs  <= PW'(a_angle) * SCALE;
      b_x0   <= XW'(gain_prod[GAIN_PROD_W-1:14]);
      b_mag  <= RW'(a_abs) << (30 - ANGLE_FRAC_BITS);
      b_zneg <= a_angle[ANGLE_W-1];
      b_last <= a_last;
      b_cand <= a_cand;
    end
  end

  assign pillar = (B0_LO <= b_lhs && b_lhs <= B0_HI) ||
                  (B1_LO <= b_lhs && b_lhs <= B1_HI) ||
                  (B2_LO <= b_lhs && b_lhs <= B2_HI) ||
                  (B3_LO <= b_lhs && b_lhs <= B3_HI);
  assign kept   = b_cand && !pillar;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (ready_c) begin
      dn_valid <= b_valid && (kept || b_last);
    end
  end

  always_ff @(posedge clk) begin
    if (ready_c && b_valid) begin
      dn_item.last <= b_last;
      dn_item.kept <= kept;
      dn_item.zneg <= b_zneg;
      dn_item.neg  <= 1'b0;
      dn_item.x    <= b_x0;
      dn_item.y    <= '0;
      dn_item.z    <= b_mag;
    end
  end

endmodule

// ===== rtl/lspf_angle_cell.sv =====
// Angle reduction cell: one conditional subtract of 2*pi scaled by 2^STEP, or,
// in the last cell, the fold into [-pi/2, pi/2]. Uses lspf_pkg.
module lspf_angle_cell #(
  parameter int STEP = 0,
  parameter bit FOLD = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  input  lspf_pkg::lspf_item_t up_item,
  output logic                 up_ready,
  output logic                 dn_valid,
  output lspf_pkg::lspf_item_t dn_item,
  input  logic                 dn_ready
);
  import lspf_pkg::*;

  localparam logic [RW-1:0] SUB   = RW'(TWO_PI_Q30 << STEP);
  localparam logic [RW-1:0] HALF  = RW'(HALF_PI_Q30);
  localparam logic [RW-1:0] UPPER = RW'(TWO_PI_Q30 - HALF_PI_Q30);
  localparam logic signed [ZW-1:0] PI_Z     = ZW'(PI_Q30);
  localparam logic signed [ZW-1:0] TWO_PI_Z = ZW'(TWO_PI_Q30);

  lspf_item_t           item_next;
  logic signed [ZW-1:0] mz;
  logic signed [ZW-1:0] v;
  logic signed [ZW-1:0] zf;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    item_next = up_item;
    mz        = signed'(up_item.z[ZW-1:0]);
    v         = mz;
    zf        = mz;
    if (FOLD) begin
      if (up_item.z <= HALF) begin
        v = mz;
      end else if (up_item.z < UPPER) begin
        v             = mz - PI_Z;
        item_next.neg = 1'b1;
      end else begin
        v = mz - TWO_PI_Z;
      end
      zf          = up_item.zneg ? -v : v;
      item_next.z = RW'(zf);
    end else if (up_item.z >= SUB) begin
      item_next.z = up_item.z - SUB;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_item <= item_next;
    end
  end

endmodule

// ===== rtl/lspf_cordic_cell.sv =====
// One CORDIC rotation stage: shifts by STAGE and steers toward zero angle.
// Uses lspf_pkg for the transaction type and the arctangent table.
module lspf_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  input  lspf_pkg::lspf_item_t up_item,
  output logic                 up_ready,
  output logic                 dn_valid,
  output lspf_pkg::lspf_item_t dn_item,
  input  logic                 dn_ready
);
  import lspf_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = signed'(ZW'(atan_q30(STAGE)));

  lspf_item_t           item_next;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] zc;
  logic signed [ZW-1:0] zn;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    item_next = up_item;
    zc        = signed'(up_item.z[ZW-1:0]);
    dx        = up_item.y >>> STAGE;
    dy        = up_item.x >>> STAGE;
    if (zc >= 0) begin
      item_next.x = up_item.x - dx;
      item_next.y = up_item.y + dy;
      zn          = zc - ATAN;
    end else begin
      item_next.x = up_item.x + dx;
      item_next.y = up_item.y - dy;
      zn          = zc + ATAN;
    end
    item_next.z = RW'(zn);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_item <= item_next;
    end
  end

endmodule

// ===== rtl/lspf_out.sv =====
// Output stage: applies the half-turn sign, rounds Q16 to mm, saturates and
// holds the result register toward the consumer. Uses lspf_pkg.
module lspf_out (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              up_valid,
  input  lspf_pkg::lspf_item_t              up_item,
  output logic                              up_ready,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [lspf_pkg::COORD_W-1:0] point_x,
  output logic signed [lspf_pkg::COORD_W-1:0] point_y,
  output logic                              point_valid,
  output logic                              end_of_scan
);
  import lspf_pkg::*;

  localparam logic signed [XW:0] RND  = (XW + 1)'(32768);
  localparam logic signed [XW:0] CMAX = (XW + 1)'(65535);

  function automatic logic signed [COORD_W-1:0] round_sat(
    input logic signed [XW-1:0] v,
    input logic                 neg
  );
    logic signed [XW:0]      e;
    logic signed [XW:0]      r;
    logic signed [COORD_W-1:0] res;
    e = (XW + 1)'(v);
    if (neg) begin
      e = -e;
    end
    r = (e + RND) >>> 16;
    if (r > CMAX) begin
      res = COORD_W'(CMAX);
    end else if (r < -CMAX) begin
      res = COORD_W'(-CMAX);
    end else begin
      res = r[COORD_W-1:0];
    end
    return res;
  endfunction

  assign up_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      point_x     <= up_item.kept ? round_sat(up_item.x, up_item.neg) : '0;
      point_y     <= up_item.kept ? round_sat(up_item.y, up_item.neg) : '0;
      point_valid <= up_item.kept;
      end_of_scan <= up_item.last;
    end
  end

endmodule

// ===== rtl/lidar_scan_point_filter.sv =====
// LiDAR scan point filter: range gate, pillar bands and CORDIC polar to Cartesian.
// The cells run in order: front end, angle cells, CORDIC cells, output register.
// Throughput is one transaction per cycle; every pipeline cell takes a new one
// whenever it is empty or its neighbor takes its content.
// Synchronous reset clears all valid bits and the stride counter, loads the
// configuration registers with their defaults and the beam angle with the default
// start angle. Uses lspf_pkg.
module lidar_scan_point_filter #(
  parameter int CORDIC_STAGES   = lspf_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_FRAC_BITS = lspf_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [lspf_pkg::CFG_AW-1:0]          cfg_addr,
  input  logic [lspf_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [lspf_pkg::RANGE_W-1:0]         range_mm,
  input  logic                                 range_finite,
  input  logic                                 scan_last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [lspf_pkg::COORD_W-1:0]  point_x,
  output logic signed [lspf_pkg::COORD_W-1:0]  point_y,
  output logic                                 point_valid,
  output logic                                 end_of_scan
);
  import lspf_pkg::*;

  localparam int RED_STEPS = 18 - ANGLE_FRAC_BITS;
  localparam int N_ANGLE   = RED_STEPS + 1;
  localparam int N_LINK    = 1 + N_ANGLE + CORDIC_STAGES;

  logic       link_valid [0:N_LINK-1];
  logic       link_ready [0:N_LINK-1];
  lspf_item_t link_item  [0:N_LINK-1];

  lspf_front #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .range_mm     (range_mm),
    .range_finite (range_finite),
    .scan_last    (scan_last),
    .dn_valid     (link_valid[0]),
    .dn_item      (link_item[0]),
    .dn_ready     (link_ready[0])
  );

  for (genvar j = 0; j < N_ANGLE; j++) begin : g_angle
    lspf_angle_cell #(
      .STEP((j < RED_STEPS) ? (RED_STEPS - 1 - j) : 0),
      .FOLD(j == RED_STEPS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (link_valid[j]),
      .up_item  (link_item[j]),
      .up_ready (link_ready[j]),
      .dn_valid (link_valid[j+1]),
      .dn_item  (link_item[j+1]),
      .dn_ready (link_ready[j+1])
    );
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    lspf_cordic_cell #(
      .STAGE(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (link_valid[N_ANGLE+i]),
      .up_item  (link_item[N_ANGLE+i]),
      .up_ready (link_ready[N_ANGLE+i]),
      .dn_valid (link_valid[N_ANGLE+i+1]),
      .dn_item  (link_item[N_ANGLE+i+1]),
      .dn_ready (link_ready[N_ANGLE+i+1])
    );
  end

  lspf_out u_out (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (link_valid[N_LINK-1]),
    .up_item     (link_item[N_LINK-1]),
    .up_ready    (link_ready[N_LINK-1]),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_valid (point_valid),
    .end_of_scan (end_of_scan)
  );

  // An empty output register means every cell upstream can move.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while the output register is empty");

  a_dropped_point_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |-> point_x == '0 && point_y == '0)
    else $error("coordinates not cleared on a transaction without a point");

  a_result_has_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |-> end_of_scan)
    else $error("transaction carries neither a point nor the end of a scan");

endmodule
